FILE: rtl/ifl_pkg.sv
// shared types, constants and control codes of the free list allocator
package ifl_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int FIELD_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int END_W      = 13;
  localparam int SIZE_W     = 13;
  localparam int HDR_W      = 14;
  localparam int ALIGN_W    = 4;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // arena geometry
  localparam int ADDR_LIMIT   = 4096;
  localparam int HDR_BYTES    = 4;
  localparam int MIN_SPLIT    = 8;
  localparam int MIN_ARENA    = 16;
  localparam int ARENA_RESET  = 4096;
  localparam int ALIGN_RESET  = 2;
  localparam int ALIGN_LG_MIN = 2;
  localparam int ALIGN_LG_MAX = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_FORMAT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_BYTES    = 1'd0,
    REG_ALIGNMENT_LOG2 = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_DISPATCH,
    ST_FORMAT,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_SPLIT_HEAD,
    ST_FREE_OLD,
    ST_RESP
  } state_t;

  // header write select
  typedef enum logic [2:0] {
    WR_NONE,
    WR_FORMAT,
    WR_FREE_CUR,
    WR_MARK_CUR,
    WR_SPLIT_TAIL,
    WR_SPLIT_HEAD,
    WR_FREE_OLD
  } wr_sel_t;

  // result capture select
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_GRANT_SPLIT,
    RES_GRANT_WHOLE,
    RES_NO_SPACE,
    RES_BAD
  } res_sel_t;

  // walk pointer update
  typedef enum logic [1:0] {
    HDR_HOLD,
    HDR_ZERO,
    HDR_NEXT
  } hdr_op_t;

  typedef struct packed {
    logic     take_req;
    hdr_op_t  hdr_op;
    logic     save_old;
    wr_sel_t  wr_sel;
    res_sel_t res_sel;
    logic     out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic fmt_pending;
    cmd_t cmd;
    logic addr_bad;
    logic hit;
    logic past;
    logic walk_end;
    logic fit;
    logic split;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/ifl_req_if.sv
// request channel: command, size and address with valid/ready
interface ifl_req_if;
  import ifl_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] address;

  modport source (output valid, command, request_size, address, input ready);
  modport sink (input valid, command, request_size, address, output ready);
endinterface

FILE: rtl/ifl_rsp_if.sv
// response channel: status, granted address and size with valid/ready
interface ifl_rsp_if;
  import ifl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  block_address;
  logic [FIELD_W-1:0]  granted_size;

  modport source (output valid, status, block_address, granted_size, input ready);
  modport sink (input valid, status, block_address, granted_size, output ready);
endinterface

FILE: rtl/implicit_free_list_allocator.sv
// top level of the first-fit implicit free list allocator
//
// Requests arrive on the req channel (command, request_size, address) and
// each one produces exactly one response on the rsp channel (status,
// block_address, granted_size); a transfer happens when valid and ready are
// both high. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce
// this. Writing arena_bytes marks a format pending, which the controller
// performs in its init state before it takes the next request. Items are
// handled one at a time. The header store is a memory with registered read,
// so each header visited takes a read state and a check state. A split adds
// a state that writes the split head. The next request is taken in the idle
// state that follows the response register load.
// After reset, req.ready stays low while header 0 is written.
// The response sits in an output register: a stalled receiver holds it while
// the next request is accepted and worked; the following response waits
// until the register is taken, and no request is accepted meanwhile.
module implicit_free_list_allocator #(
  parameter int ARENA_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifl_pkg::CFG_DATA_W-1:0] cfg_data,
  ifl_req_if.sink                       req,
  ifl_rsp_if.source                     rsp
);
  import ifl_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  ifl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  ifl_datapath #(
    .ARENA_WORDS(ARENA_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (req.command),
    .in_request_size  (req.request_size),
    .in_address       (req.address),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_status       (rsp.status),
    .out_block_address(rsp.block_address),
    .out_granted_size (rsp.granted_size)
  );

endmodule

FILE: rtl/ifl_ram.sv
// generic single write port ram with registered read
module ifl_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ifl_datapath.sv
// allocator datapath: config registers, header store, walk pointer, result registers
module ifl_datapath #(
  parameter int ARENA_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ifl_pkg::CMD_W-1:0]     in_command,
  input  logic [ifl_pkg::FIELD_W-1:0]   in_request_size,
  input  logic [ifl_pkg::FIELD_W-1:0]   in_address,
  input  ifl_pkg::dp_ctrl_t             ctrl,
  output ifl_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ifl_pkg::STATUS_W-1:0]  out_status,
  output logic [ifl_pkg::FIELD_W-1:0]   out_block_address,
  output logic [ifl_pkg::FIELD_W-1:0]   out_granted_size
);
  import ifl_pkg::*;

  localparam int END_MAX = (4 * ARENA_WORDS < ADDR_LIMIT) ? 4 * ARENA_WORDS : ADDR_LIMIT;
  localparam int WADDR_W = $clog2(ARENA_WORDS);

  logic [END_W-1:0]   arena_bytes;
  logic [ALIGN_W-1:0] align_lg;
  logic               fmt_pending;

  cmd_t               cmd_q;
  logic [SIZE_W-1:0]  rounded;
  logic [FIELD_W-1:0] addr_q;
  logic [END_W-1:0]   hdr;
  logic [END_W-1:0]   old_hdr;
  logic [HDR_W-1:0]   old_word;

  status_t            res_status;
  logic [FIELD_W-1:0] res_addr;
  logic [FIELD_W-1:0] res_size;

  logic [END_W-1:0]   arena_floor;
  logic [END_W-1:0]   arena_end;
  logic [ALIGN_W-1:0] lg_sat;
  logic [SIZE_W-1:0]  align_mask;
  logic [SIZE_W-1:0]  rounded_in;

  logic [HDR_W-1:0]   rdata;
  logic               cur_used;
  logic [SIZE_W-1:0]  cur_sz;
  logic [SIZE_W-1:0]  left;
  logic [END_W:0]     next_hdr;
  logic [END_W:0]     pay;
  logic [END_W:0]     tail_hdr;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [HDR_W-1:0]   ram_wdata;
  logic [WADDR_W-1:0] ram_raddr;

  // effective arena end, word aligned and saturated
  always_comb begin
    arena_floor = {arena_bytes[END_W-1:2], 2'b00};
    if (arena_floor > END_W'(END_MAX)) begin
      arena_end = END_W'(END_MAX);
    end else if (arena_floor < END_W'(MIN_ARENA)) begin
      arena_end = END_W'(MIN_ARENA);
    end else begin
      arena_end = arena_floor;
    end
  end

  // request size rounded up to the saturated alignment
  always_comb begin
    if (align_lg < ALIGN_W'(ALIGN_LG_MIN)) begin
      lg_sat = ALIGN_W'(ALIGN_LG_MIN);
    end else if (align_lg > ALIGN_W'(ALIGN_LG_MAX)) begin
      lg_sat = ALIGN_W'(ALIGN_LG_MAX);
    end else begin
      lg_sat = align_lg;
    end
    align_mask = (SIZE_W'(1) << lg_sat) - SIZE_W'(1);
    rounded_in = (SIZE_W'(in_request_size) + align_mask) & ~align_mask;
  end

  // configuration registers and format request
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes <= END_W'(ARENA_RESET);
      align_lg    <= ALIGN_W'(ALIGN_RESET);
      fmt_pending <= 1'b1;
    end else begin
      if (cfg_we && reg_idx_t'(cfg_index) == REG_ARENA_BYTES) begin
        arena_bytes <= cfg_data[END_W-1:0];
        fmt_pending <= 1'b1;
      end else if (ctrl.wr_sel == WR_FORMAT) begin
        fmt_pending <= 1'b0;
      end
      if (cfg_we && reg_idx_t'(cfg_index) == REG_ALIGNMENT_LOG2) begin
        align_lg <= cfg_data[ALIGN_W-1:0];
      end
    end
  end

  // header under the walk pointer
  always_comb begin
    cur_used = rdata[0];
    cur_sz   = rdata[HDR_W-1:1];
    left     = cur_sz - rounded;
    next_hdr = {1'b0, hdr} + (END_W+1)'(HDR_BYTES) + {1'b0, cur_sz};
    pay      = {1'b0, hdr} + (END_W+1)'(HDR_BYTES);
    tail_hdr = pay + {1'b0, rounded};
  end

  // status toward the controller
  always_comb begin
    stat.fmt_pending = fmt_pending;
    stat.cmd         = cmd_q;
    stat.addr_bad    = (addr_q[1:0] != 2'b00) || (addr_q < FIELD_W'(HDR_BYTES)) ||
                       (END_W'(addr_q) >= arena_end);
    stat.hit         = (pay == (END_W+1)'(addr_q));
    stat.past        = (pay > (END_W+1)'(addr_q));
    stat.walk_end    = (next_hdr >= {1'b0, arena_end});
    stat.fit         = !cur_used && (cur_sz >= rounded);
    stat.split       = (left >= SIZE_W'(MIN_SPLIT));
    stat.out_free    = !out_valid || out_ready;
  end

  // request capture and walk pointer
  always_ff @(posedge clk) begin
    if (ctrl.take_req) begin
      cmd_q   <= cmd_t'(in_command);
      rounded <= rounded_in;
      addr_q  <= in_address;
    end
    case (ctrl.hdr_op)
      HDR_ZERO: hdr <= '0;
      HDR_NEXT: hdr <= next_hdr[END_W-1:0];
      default:  hdr <= hdr;
    endcase
    if (ctrl.save_old) begin
      old_hdr  <= hdr;
      old_word <= {cur_sz, 1'b0};
    end
  end

  // header write mux
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = WADDR_W'(hdr[END_W-1:2]);
    ram_wdata = '0;
    case (ctrl.wr_sel)
      WR_FORMAT: begin
        ram_waddr = '0;
        ram_wdata = {arena_end - END_W'(HDR_BYTES), 1'b0};
      end
      WR_FREE_CUR: ram_wdata = {cur_sz, 1'b0};
      WR_MARK_CUR: ram_wdata = {cur_sz, 1'b1};
      WR_SPLIT_TAIL: begin
        ram_waddr = WADDR_W'(tail_hdr[END_W-1:2]);
        ram_wdata = {left - SIZE_W'(HDR_BYTES), 1'b0};
      end
      WR_SPLIT_HEAD: ram_wdata = {rounded, 1'b1};
      WR_FREE_OLD: begin
        ram_waddr = WADDR_W'(old_hdr[END_W-1:2]);
        // the old block may be the one just granted, possibly split
        ram_wdata = (old_hdr == hdr) ? {1'b0, res_size, 1'b0} : old_word;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = WADDR_W'(hdr[END_W-1:2]);

  ifl_ram #(
    .WIDTH(HDR_W),
    .DEPTH(ARENA_WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // result capture
  always_ff @(posedge clk) begin
    case (ctrl.res_sel)
      RES_OK: begin
        res_status <= STATUS_OK;
        res_addr   <= '0;
        res_size   <= '0;
      end
      RES_GRANT_SPLIT: begin
        res_status <= STATUS_OK;
        res_addr   <= pay[FIELD_W-1:0];
        res_size   <= rounded[FIELD_W-1:0];
      end
      RES_GRANT_WHOLE: begin
        res_status <= STATUS_OK;
        res_addr   <= pay[FIELD_W-1:0];
        res_size   <= cur_sz[FIELD_W-1:0];
      end
      RES_NO_SPACE: begin
        res_status <= STATUS_NO_SPACE;
        res_addr   <= '0;
        res_size   <= '0;
      end
      RES_BAD: begin
        res_status <= STATUS_BAD_ADDR;
        res_addr   <= '0;
        res_size   <= '0;
      end
      default: res_status <= res_status;
    endcase
  end

  // output register, holds until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_status        <= res_status;
      out_block_address <= res_addr;
      out_granted_size  <= res_size;
    end
  end

endmodule

FILE: rtl/ifl_ctrl.sv
// allocator controller: sequences header walks, writes and the response
module ifl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifl_pkg::dp_stat_t stat,
  output ifl_pkg::dp_ctrl_t ctrl
);
  import ifl_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctrl.take_req = 1'b0;
    ctrl.hdr_op   = HDR_HOLD;
    ctrl.save_old = 1'b0;
    ctrl.wr_sel   = WR_NONE;
    ctrl.res_sel  = RES_NONE;
    ctrl.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (stat.fmt_pending) begin
          state_next = ST_INIT;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            ctrl.take_req = 1'b1;
            ctrl.hdr_op   = HDR_ZERO;
            state_next    = ST_DISPATCH;
          end
        end
      end
      // arena format after reset or an arena size write
      ST_INIT: begin
        ctrl.wr_sel = WR_FORMAT;
        state_next  = ST_IDLE;
      end
      ST_DISPATCH: begin
        case (stat.cmd)
          CMD_ALLOC:   state_next = ST_ALLOC_RD;
          CMD_FREE:    state_next = ST_FIND_RD;
          CMD_REALLOC: state_next = ST_FIND_RD;
          default:     state_next = ST_FORMAT;
        endcase
      end
      ST_FORMAT: begin
        ctrl.wr_sel  = WR_FORMAT;
        ctrl.res_sel = RES_OK;
        state_next   = ST_RESP;
      end
      // look up the block that owns the given payload address
      ST_FIND_RD: begin
        if (stat.addr_bad) begin
          ctrl.res_sel = RES_BAD;
          state_next   = ST_RESP;
        end else begin
          state_next = ST_FIND_CHK;
        end
      end
      ST_FIND_CHK: begin
        if (stat.hit) begin
          if (stat.cmd == CMD_FREE) begin
            ctrl.wr_sel  = WR_FREE_CUR;
            ctrl.res_sel = RES_OK;
            state_next   = ST_RESP;
          end else begin
            ctrl.save_old = 1'b1;
            ctrl.hdr_op   = HDR_ZERO;
            state_next    = ST_ALLOC_RD;
          end
        end else if (stat.past || stat.walk_end) begin
          ctrl.res_sel = RES_BAD;
          state_next   = ST_RESP;
        end else begin
          ctrl.hdr_op = HDR_NEXT;
          state_next  = ST_FIND_RD;
        end
      end
      // first fit walk
      ST_ALLOC_RD: state_next = ST_ALLOC_CHK;
      ST_ALLOC_CHK: begin
        if (stat.fit) begin
          if (stat.split) begin
            ctrl.wr_sel  = WR_SPLIT_TAIL;
            ctrl.res_sel = RES_GRANT_SPLIT;
            state_next   = ST_SPLIT_HEAD;
          end else begin
            ctrl.wr_sel  = WR_MARK_CUR;
            ctrl.res_sel = RES_GRANT_WHOLE;
            state_next   = (stat.cmd == CMD_REALLOC) ? ST_FREE_OLD : ST_RESP;
          end
        end else if (stat.walk_end) begin
          ctrl.res_sel = RES_NO_SPACE;
          state_next   = ST_RESP;
        end else begin
          ctrl.hdr_op = HDR_NEXT;
          state_next  = ST_ALLOC_RD;
        end
      end
      ST_SPLIT_HEAD: begin
        ctrl.wr_sel = WR_SPLIT_HEAD;
        state_next  = (stat.cmd == CMD_REALLOC) ? ST_FREE_OLD : ST_RESP;
      end
      ST_FREE_OLD: begin
        ctrl.wr_sel = WR_FREE_OLD;
        state_next  = ST_RESP;
      end
      // wait for room in the output register
      ST_RESP: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/ifl_checker.sv
// port level checks of the allocator and their bind to the top level
module ifl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ifl_pkg::STATUS_W-1:0] rsp_status,
  input logic [ifl_pkg::FIELD_W-1:0]  rsp_block_address,
  input logic [ifl_pkg::FIELD_W-1:0]  rsp_granted_size
);
  import ifl_pkg::*;

  // reset leaves no response pending and the arena not yet formatted
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("response or ready after reset");

  // any failure reports zero address and size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STATUS_OK |-> rsp_block_address == '0 &&
    rsp_granted_size == '0)
    else $error("failed response carries an address or size");

  // payload addresses are always word aligned
  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_block_address[1:0] == 2'b00)
    else $error("misaligned block address");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
    $stable(rsp_block_address) && $stable(rsp_granted_size))
    else $error("stalled response changed");

endmodule

bind implicit_free_list_allocator ifl_checker u_ifl_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_block_address(rsp.block_address),
  .rsp_granted_size (rsp.granted_size)
);

FILE: sim/ifl_alloc_checker.sv
// checker for the free list allocator: predicts each response and compares it
`timescale 1ns / 1ps

module ifl_alloc_checker #(
  parameter int ARENA_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifl_pkg::CFG_DATA_W-1:0] cfg_data,
  ifl_req_if                             req,
  ifl_rsp_if                             rsp,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked,
  output int                             grants,
  output int                             refusals,
  output int                             rejects
);
  import ifl_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] block_address;
    logic [FIELD_W-1:0] granted_size;
  } alloc_result_t;

  // shadow copy of the header store and the registers
  logic [HDR_W-1:0]      headers [ARENA_WORDS];
  logic [CFG_DATA_W-1:0] arena_reg;
  logic [ALIGN_W-1:0]    align_reg;
  alloc_result_t         expected_q[$];

  int n_bad;
  int n_checked;
  int n_grant;
  int n_refuse;
  int n_reject;

  // arena size actually in use after rounding and saturation
  function automatic int arena_limit();
    int lim;
    lim = int'(arena_reg) & ~3;
    if (lim > ADDR_LIMIT) lim = ADDR_LIMIT;
    if (lim > ARENA_WORDS * 4) lim = ARENA_WORDS * 4;
    if (lim < MIN_ARENA) lim = MIN_ARENA;
    return lim;
  endfunction

  // one free block spanning the arena
  function automatic void wipe_arena();
    foreach (headers[w]) headers[w] = '0;
    headers[0] = HDR_W'((arena_limit() - HDR_BYTES) << 1);
  endfunction

  // header word of the block whose payload starts at addr, -1 if none
  function automatic int locate_block(int addr);
    int lim;
    int pos;
    int pay;
    lim = arena_limit();
    pos = 0;
    if ((addr % 4) != 0 || addr < HDR_BYTES || addr >= lim) return -1;
    while (pos < ARENA_WORDS && pos * 4 < lim) begin
      pay = (pos + 1) * 4;
      if (pay == addr) return pos;
      if (pay > addr) break;
      pos = pos + 1 + (int'(headers[pos] >> 1) >> 2);
    end
    return -1;
  endfunction

  // first-fit walk with split of a large enough remainder
  function automatic status_t first_fit(int want, output int addr, output int size);
    int lim;
    int lg;
    int align;
    int rounded;
    int pos;
    int hdr;
    int sz;
    int left;
    int np;
    addr = 0;
    size = 0;
    lim = arena_limit();
    lg = int'(align_reg);
    if (lg < ALIGN_LG_MIN) lg = ALIGN_LG_MIN;
    if (lg > ALIGN_LG_MAX) lg = ALIGN_LG_MAX;
    align = 1 << lg;
    rounded = (want + align - 1) & ~(align - 1);
    pos = 0;
    while (pos < ARENA_WORDS && pos * 4 < lim) begin
      hdr = int'(headers[pos]);
      sz = hdr >> 1;
      if ((hdr & 1) == 0 && sz >= rounded) begin
        left = sz - rounded;
        if (left >= MIN_SPLIT) begin
          np = pos + 1 + (rounded >> 2);
          headers[pos] = HDR_W'((rounded << 1) | 1);
          if (np < ARENA_WORDS) headers[np] = HDR_W'((left - HDR_BYTES) << 1);
          sz = rounded;
        end else begin
          headers[pos] = HDR_W'(hdr | 1);
        end
        addr = (pos + 1) * 4;
        size = sz;
        return STATUS_OK;
      end
      pos = pos + 1 + (sz >> 2);
    end
    return STATUS_NO_SPACE;
  endfunction

  // apply one request to the shadow state and form its response
  function automatic alloc_result_t predict_response(cmd_t cmd, int want, int addr);
    alloc_result_t r;
    status_t st;
    int old;
    int ga;
    int gs;
    st = STATUS_OK;
    ga = 0;
    gs = 0;
    case (cmd)
      CMD_ALLOC: begin
        st = first_fit(want, ga, gs);
      end
      CMD_FREE: begin
        old = locate_block(addr);
        if (old < 0) st = STATUS_BAD_ADDR;
        else headers[old][0] = 1'b0;
      end
      CMD_REALLOC: begin
        old = locate_block(addr);
        if (old < 0) begin
          st = STATUS_BAD_ADDR;
        end else begin
          st = first_fit(want, ga, gs);
          if (st == STATUS_OK) headers[old][0] = 1'b0;
        end
      end
      default: begin
        wipe_arena();
      end
    endcase
    if (st != STATUS_OK) begin
      ga = 0;
      gs = 0;
    end
    r.status = st;
    r.block_address = FIELD_W'(ga);
    r.granted_size = FIELD_W'(gs);
    return r;
  endfunction

  // watch transfers: compare responses first, then track config and requests
  always @(posedge clk) begin
    alloc_result_t exp;
    if (rst) begin
      arena_reg = CFG_DATA_W'(ARENA_RESET);
      align_reg = ALIGN_W'(ALIGN_RESET);
      wipe_arena();
      expected_q.delete();
      n_bad = 0;
      n_checked = 0;
      n_grant = 0;
      n_refuse = 0;
      n_reject = 0;
    end else begin
      // response transfer
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("ifl_alloc_checker: unexpected response status %0d addr %0d size %0d",
                     rsp.status, rsp.block_address, rsp.granted_size);
        end else begin
          exp = expected_q.pop_front();
          n_checked++;
          if (rsp.status !== exp.status || rsp.block_address !== exp.block_address ||
              rsp.granted_size !== exp.granted_size) begin
            n_bad++;
            if (n_bad <= 10)
              $display("ifl_alloc_checker: item %0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                       n_checked, exp.status, exp.block_address, exp.granted_size,
                       rsp.status, rsp.block_address, rsp.granted_size);
          end
          case (exp.status)
            STATUS_OK:       if (exp.block_address != 0) n_grant++;
            STATUS_NO_SPACE: n_refuse++;
            default:         n_reject++;
          endcase
        end
      end
      // register write
      if (cfg_we) begin
        if (cfg_index == REG_ARENA_BYTES) begin
          arena_reg = cfg_data;
          wipe_arena();
        end else begin
          align_reg = cfg_data[ALIGN_W-1:0];
        end
      end
      // request transfer
      if (req.valid && req.ready)
        expected_q.push_back(predict_response(cmd_t'(req.command), int'(req.request_size),
                                              int'(req.address)));
    end
    mismatches  <= n_bad;
    outstanding <= expected_q.size();
    checked     <= n_checked;
    grants      <= n_grant;
    refusals    <= n_refuse;
    rejects     <= n_reject;
  end

endmodule

FILE: sim/tb_implicit_free_list_allocator.sv
// testbench top: clock, reset, register setup, request traffic and verdict
`timescale 1ns / 1ps

module tb_implicit_free_list_allocator;
  import ifl_pkg::*;

  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 95;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;
  int grants;
  int refusals;
  int rejects;

  int sent = 0;
  int burst_left = 0;
  int unsigned live_q[$];
  bit held_off = 1'b0;

  // raw register values per phase, extremes and out-of-range values among them
  int arena_raw [N_PHASES] = '{16, 4096, 8191, 0, 1002, 258, 4096};
  int align_raw [N_PHASES] = '{2, 8, 15, 0, 3, 5, 2};

  ifl_req_if req_ch();
  ifl_rsp_if rsp_ch();

  implicit_free_list_allocator #(.ARENA_WORDS(1024)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  ifl_alloc_checker #(.ARENA_WORDS(1024)) alloc_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .grants      (grants),
    .refusals    (refusals),
    .rejects     (rejects)
  );

  always #6 clk = ~clk;

  // one request transfer, with bursts and random gaps between them
  task automatic issue(cmd_t cmd, int want, int addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.request_size <= FIELD_W'(want);
    req_ch.address      <= FIELD_W'(addr);
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // stop offering and wait until every response is in
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small requests scaled to the arena, some anywhere in range
  function automatic int pick_size(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, lim / 16);
    if (r < 85) return $urandom_range(0, lim / 4);
    if (r < 95) return $urandom_range(0, 4095);
    return $urandom_range(4000, 4095);
  endfunction

  // take a live payload address out of the pool
  function automatic int take_live();
    int idx;
    int addr;
    idx = $urandom_range(0, live_q.size() - 1);
    addr = live_q[idx];
    live_q.delete(idx);
    return addr;
  endfunction

  // random traffic: mostly alloc/free/realloc of live blocks, some noise
  task automatic random_traffic(int n, int lim);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40 || (live_q.size() == 0 && r < 85)) begin
        issue(CMD_ALLOC, pick_size(lim), $urandom_range(0, 4095));
      end else if (r < 65) begin
        issue(CMD_FREE, $urandom_range(0, 4095), take_live());
      end else if (r < 85) begin
        issue(CMD_REALLOC, pick_size(lim), take_live());
      end else if (r < 88) begin
        live_q.delete();
        issue(CMD_FORMAT, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (r < 94) begin
        issue($urandom_range(0, 1) ? CMD_FREE : CMD_REALLOC, pick_size(lim),
              $urandom_range(0, 4095));
      end else begin
        // aligned address that may land inside a payload or past the end
        issue($urandom_range(0, 1) ? CMD_FREE : CMD_REALLOC, pick_size(lim),
              $urandom_range(0, lim / 4 + 2) * 4);
      end
    end
  endtask

  // record granted addresses on the falling clock edge ahead of the response transfer
  always @(negedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STATUS_OK &&
        rsp_ch.block_address != 0)
      live_q.push_back(32'(rsp_ch.block_address));
  end

  // receiver: ready pattern changes every so often, one long hold-off
  initial begin
    int mode;
    int span;
    int tick;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        if (!held_off && checked >= 200) begin
          rsp_ch.ready <= 1'b0;
          repeat (400) @(posedge clk);
          held_off = 1'b1;
        end else begin
          case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= (tick % 4 == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int lim;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_ARENA_BYTES;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_ALLOC;
    req_ch.request_size <= '0;
    req_ch.address      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // directed: reset arena of 4096 bytes, 4-byte alignment
    issue(CMD_ALLOC, 0, 0);           // zero request, split
    issue(CMD_ALLOC, 4095, 4095);     // too large
    issue(CMD_ALLOC, 1, 0);           // rounds up to 4
    issue(CMD_ALLOC, 13, 0);          // rounds up to 16
    issue(CMD_FREE, 0, 4);
    issue(CMD_FREE, 0, 4);            // free of a free block
    issue(CMD_FREE, 0, 2);            // misaligned
    issue(CMD_FREE, 0, 0);            // below the first payload
    issue(CMD_FREE, 0, 4092);         // inside a payload
    issue(CMD_FREE, 0, 4095);
    issue(CMD_REALLOC, 20, 8);
    issue(CMD_REALLOC, 20, 3);        // bad address, no allocation
    issue(CMD_REALLOC, 4040, 16);     // no space, old block kept
    issue(CMD_ALLOC, 0, 0);           // reuses the empty block
    issue(CMD_FORMAT, 4095, 4095);
    issue(CMD_ALLOC, 4092, 0);        // whole arena, no split
    issue(CMD_ALLOC, 0, 0);           // nothing left
    issue(CMD_FREE, 0, 4);
    issue(CMD_ALLOC, 4086, 0);        // remainder too small to split
    issue(CMD_FORMAT, 0, 0);
    issue(CMD_ALLOC, 4084, 0);        // remainder of exactly the split minimum
    issue(CMD_REALLOC, 0, 4);
    issue(CMD_FREE, 0, 4096 - 4);
    drain();
    live_q.delete();

    // random phases over several register settings
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_ARENA_BYTES, arena_raw[p]);
      write_reg(REG_ALIGNMENT_LOG2, align_raw[p]);
      live_q.delete();
      lim = arena_raw[p] & ~3;
      if (lim > ADDR_LIMIT) lim = ADDR_LIMIT;
      if (lim < MIN_ARENA) lim = MIN_ARENA;
      random_traffic(PHASE_ITEMS, lim);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d requests over %0d register settings, %0d responses checked",
             sent, N_PHASES + 1, checked);
    $display("tb: %0d grants, %0d no-space, %0d bad-address, long receiver hold %0s",
             grants, refusals, rejects, held_off ? "done" : "missed");
    if (mismatches == 0 && outstanding == 0)
      $display("tb_implicit_free_list_allocator: done, clean");
    else
      $display("tb_implicit_free_list_allocator: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    #400_000_000;
    $display("tb_implicit_free_list_allocator: done, errors");
    $finish;
  end

endmodule
